// File: design/mascu_pkg.sv
// shared types and constants for the mean-above-sigma-cutoff unit
package mascu_pkg;

	localparam int SAMPLE_W = 24;
	localparam int QCOUNT_W = 11;
	localparam int MULT_W   = 5;
	localparam int SQ_W     = 48;
	localparam int ROOT_W   = 24;
	localparam logic signed [MULT_W-1:0] MULT_RESET = 5'sd1;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_value;
		logic                       sample_valid;
		logic                       last_sample;
	} in_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] mean_above_cutoff;
		logic                       no_result;
		logic                       overflow_dropped;
		logic [QCOUNT_W-1:0]        qualifying_count;
	} out_t;

	typedef enum logic [1:0] {
		DIV_SUM = 2'd0,
		DIV_SQ  = 2'd1,
		DIV_ACC = 2'd2
	} div_sel_t;

	typedef struct packed {
		logic     load;
		logic     div_start;
		div_sel_t div_sel;
		logic     sqrt_start;
		logic     cut_cap;
		logic     pass_en;
		logic     out_load;
		logic     clear;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic div_busy;
		logic div_done;
		logic sqrt_done;
		logic pass_done;
		logic qual_zero;
	} sts_t;

endpackage

// File: design/mean_above_sigma_cutoff_unit.sv
// top level: mean of samples at or above mean plus a multiple of sigma
//
//  channel   direction  handshake               word
//  item      in         item_valid/item_stall   mascu_pkg::in_t
//  result    out        result_valid/result_stall mascu_pkg::out_t
//  cfg       in         cfg_write               cfg_data (sigma multiplier)
//
// samples load one per cycle into the store while no computation runs
// after the last word: up to three divisions of a QW-bit numerator (QW = 47 +
// clog2(MAX_SAMPLES+1), 58 at the default), a square root, one pass over the
// store and the sequencing states between them
// reset clears counts, sums and flags; the store itself is not cleared
// a stalled result holds; input is taken again once the result is registered
module mean_above_sigma_cutoff_unit #(
	parameter int MAX_SAMPLES = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  mascu_pkg::in_t               item,
	output logic                         result_valid,
	input  logic                         result_stall,
	output mascu_pkg::out_t              result,
	input  logic                         cfg_write,
	input  logic [mascu_pkg::MULT_W-1:0] cfg_data
);

	mascu_pkg::cmd_t cmd;
	mascu_pkg::sts_t sts;

	mascu_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_last    (item.last_sample),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	mascu_dp #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.item      (item),
		.cfg_write (cfg_write),
		.cfg_data  (cfg_data),
		.result    (result)
	);

endmodule

// File: design/mascu_div.sv
// restoring unsigned divider, one quotient bit per cycle
module mascu_div #(
	parameter int NW = 58,
	parameter int DW = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          busy,
	output logic          done,
	output logic [NW-1:0] quo,
	output logic          rem_nz
);

	localparam int CNT_W = $clog2(NW + 1);

	logic [NW-1:0]    quo_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DW:0]      shifted;
	logic [DW:0]      trial;
	logic             fits;

	assign shifted = {rem_q, quo_q[NW-1]};
	assign trial   = shifted - {1'b0, den_q};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (start) begin
				cnt_q <= CNT_W'(NW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? trial[DW-1:0] : shifted[DW-1:0];
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	assign busy   = (cnt_q != '0);
	assign done   = done_q;
	assign quo    = quo_q;
	assign rem_nz = (rem_q != '0);

endmodule

// File: design/mascu_dp.sv
// datapath: sample store, running sums, divider, root and qualifying pass
module mascu_dp #(
	parameter int MAX_SAMPLES = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  mascu_pkg::cmd_t                  cmd,
	output mascu_pkg::sts_t                  sts,
	input  mascu_pkg::in_t                   item,
	input  logic                             cfg_write,
	input  logic [mascu_pkg::MULT_W-1:0]     cfg_data,
	output mascu_pkg::out_t                  result
);

	localparam int CW = $clog2(MAX_SAMPLES + 1);
	localparam int AW = $clog2(MAX_SAMPLES);
	localparam int SW = mascu_pkg::SAMPLE_W + CW;
	localparam int QW = 2 * mascu_pkg::SAMPLE_W - 1 + CW;
	localparam int RW = mascu_pkg::ROOT_W;
	localparam int XW = mascu_pkg::SAMPLE_W;
	localparam int SCW = $clog2(RW + 1);
	localparam int MULT_W_L = mascu_pkg::MULT_W;
	localparam int SQ_W_L = mascu_pkg::SQ_W;

	// store and running sums
	logic signed [XW-1:0]   mem [MAX_SAMPLES];
	logic [CW-1:0]          count_q;
	logic signed [SW-1:0]   sum_q;
	logic [QW-1:0]          sqsum_q;
	logic                   dropped_q;
	logic [2*XW-1:0]        sq_s1;
	logic                   sqv_s1;
	logic signed [MULT_W_L-1:0] mult_q;
	logic                   store_en;

	assign store_en = cmd.load && item.sample_valid && (count_q != CW'(MAX_SAMPLES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mult_q <= mascu_pkg::MULT_RESET;
		end else if (cfg_write) begin
			mult_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			sum_q     <= '0;
			sqsum_q   <= '0;
			dropped_q <= 1'b0;
			sqv_s1    <= 1'b0;
		end else if (cmd.clear) begin
			count_q   <= '0;
			sum_q     <= '0;
			sqsum_q   <= '0;
			dropped_q <= 1'b0;
			sqv_s1    <= 1'b0;
		end else begin
			sqv_s1 <= store_en;
			if (store_en) begin
				count_q <= count_q + CW'(1);
				sum_q   <= sum_q + SW'(item.sample_value);
			end
			if (cmd.load && item.sample_valid && !store_en) begin
				dropped_q <= 1'b1;
			end
			// square lands in the cycle after its sample
			if (sqv_s1) begin
				sqsum_q <= sqsum_q + {{(QW-2*XW){1'b0}}, sq_s1};
			end
		end
	end

	always_ff @(posedge clk) begin
		sq_s1 <= unsigned'((2*XW)'(item.sample_value) * (2*XW)'(item.sample_value));
	end

	// divider shared by mean, mean square and final average
	logic                   div_busy;
	logic                   div_done;
	logic [QW-1:0]          div_quo;
	logic                   div_rnz;
	logic [QW-1:0]          div_num;
	logic [CW-1:0]          div_den;
	logic                   div_neg;
	logic                   neg_q;
	mascu_pkg::div_sel_t    sel_q;
	logic signed [SW-1:0]   acc_q;
	logic [CW-1:0]          qual_q;
	logic [SW-1:0]          mag;
	logic signed [SW-1:0]   signed_src;

	always_comb begin
		signed_src = (cmd.div_sel == mascu_pkg::DIV_ACC) ? acc_q : sum_q;
		div_neg    = signed_src[SW-1];
		mag        = div_neg ? unsigned'(-signed_src) : unsigned'(signed_src);
		case (cmd.div_sel)
			mascu_pkg::DIV_SQ: begin
				div_num = sqsum_q;
				div_den = count_q;
			end
			mascu_pkg::DIV_ACC: begin
				div_num = {{(QW-SW){1'b0}}, mag};
				div_den = qual_q;
			end
			default: begin
				div_num = {{(QW-SW){1'b0}}, mag};
				div_den = count_q;
			end
		endcase
	end

	mascu_div #(.NW(QW), .DW(CW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo),
		.rem_nz (div_rnz)
	);

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			sel_q <= cmd.div_sel;
			neg_q <= div_neg;
		end
	end

	// floor of a signed quotient: negative magnitudes round away from zero
	logic [XW:0]          q_mag;
	logic [XW:0]          q_signed;
	logic signed [XW-1:0] mean_q;
	logic [SQ_W_L-1:0]    msq_q;
	logic signed [XW-1:0] res_q;
	logic [SQ_W_L-1:0]    mean_sq_s1;

	assign q_mag    = div_quo[XW:0] + (XW+1)'(neg_q && div_rnz);
	assign q_signed = neg_q ? (~q_mag + (XW+1)'(1)) : q_mag;

	always_ff @(posedge clk) begin
		if (div_done && sel_q == mascu_pkg::DIV_SUM) begin
			mean_q <= q_signed[XW-1:0];
		end
		if (div_done && sel_q == mascu_pkg::DIV_SQ) begin
			msq_q <= div_quo[SQ_W_L-1:0];
		end
		mean_sq_s1 <= unsigned'(SQ_W_L'(mean_q) * SQ_W_L'(mean_q));
	end

	// bit-pair square root of the clamped variance
	logic [SQ_W_L-1:0] rad_q;
	logic [RW+1:0]     srem_q;
	logic [RW-1:0]     root_q;
	logic [SCW-1:0]    scnt_q;
	logic              sdone_q;
	logic [SQ_W_L:0]   var_raw;
	logic [RW+1:0]     srem_sh;
	logic [RW+1:0]     strial;
	logic              sfits;

	assign var_raw = {1'b0, msq_q} - {1'b0, mean_sq_s1};
	assign srem_sh = (RW+2)'({srem_q, rad_q[SQ_W_L-1 -: 2]});
	assign strial  = {root_q, 2'b01};
	assign sfits   = srem_sh >= strial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scnt_q  <= '0;
			sdone_q <= 1'b0;
		end else begin
			sdone_q <= (scnt_q == SCW'(1));
			if (cmd.sqrt_start) begin
				scnt_q <= SCW'(RW);
			end else if (scnt_q != '0) begin
				scnt_q <= scnt_q - SCW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sqrt_start) begin
			// rounding can leave the variance slightly negative
			rad_q  <= var_raw[SQ_W_L] ? '0 : var_raw[SQ_W_L-1:0];
			srem_q <= '0;
			root_q <= '0;
		end else if (scnt_q != '0) begin
			rad_q  <= {rad_q[SQ_W_L-3:0], 2'b00};
			srem_q <= sfits ? (srem_sh - strial) : srem_sh;
			root_q <= {root_q[RW-2:0], sfits};
		end
	end

	// cutoff and qualifying pass over the store
	logic signed [31:0]     cutoff_q;
	logic signed [MULT_W_L+RW:0] scaled;
	logic [CW-1:0]          idx_q;
	logic                   pv_s1;
	logic signed [XW-1:0]   rd_s1;

	assign scaled = mult_q * signed'({1'b0, root_q});

	always_ff @(posedge clk) begin
		if (store_en) begin
			mem[count_q[AW-1:0]] <= item.sample_value;
		end
		rd_s1 <= mem[idx_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.cut_cap) begin
			cutoff_q <= 32'(mean_q) + 32'(scaled);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			pv_s1  <= 1'b0;
			acc_q  <= '0;
			qual_q <= '0;
			res_q  <= '0;
		end else if (cmd.clear || cmd.cut_cap) begin
			idx_q  <= '0;
			pv_s1  <= 1'b0;
			acc_q  <= '0;
			qual_q <= '0;
			res_q  <= '0;
		end else begin
			if (cmd.pass_en) begin
				pv_s1 <= (idx_q != count_q);
				if (idx_q != count_q) begin
					idx_q <= idx_q + CW'(1);
				end
			end else begin
				pv_s1 <= 1'b0;
			end
			if (pv_s1 && (32'(rd_s1) >= cutoff_q)) begin
				acc_q  <= acc_q + SW'(rd_s1);
				qual_q <= qual_q + CW'(1);
			end
			if (div_done && sel_q == mascu_pkg::DIV_ACC) begin
				res_q <= q_signed[XW-1:0];
			end
		end
	end

	// result word register
	logic [CW+mascu_pkg::QCOUNT_W-1:0] qual_wide;

	assign qual_wide = {{mascu_pkg::QCOUNT_W{1'b0}}, qual_q};

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			result.mean_above_cutoff <= res_q;
			result.no_result         <= (qual_q == '0);
			result.overflow_dropped  <= dropped_q;
			result.qualifying_count  <= qual_wide[mascu_pkg::QCOUNT_W-1:0];
		end
	end

	assign sts.empty     = (count_q == '0);
	assign sts.div_busy  = div_busy;
	assign sts.div_done  = div_done;
	assign sts.sqrt_done = sdone_q;
	assign sts.pass_done = (idx_q == count_q) && !pv_s1;
	assign sts.qual_zero = (qual_q == '0);

endmodule

// File: design/mascu_ctrl.sv
// controller: sequences load, statistics, root, pass and result hand-off
module mascu_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	input  logic            item_last,
	output logic            item_stall,
	output logic            result_valid,
	input  logic            result_stall,
	input  mascu_pkg::sts_t sts,
	output mascu_pkg::cmd_t cmd
);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_CHECK = 9'b000000010,
		ST_MEAN  = 9'b000000100,
		ST_MSQ   = 9'b000001000,
		ST_VAR   = 9'b000010000,
		ST_SQRT  = 9'b000100000,
		ST_CUT   = 9'b001000000,
		ST_PASS  = 9'b010000000,
		ST_DONE  = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   slot_free;
	logic   accept;
	logic   res_wait_q;

	assign item_stall   = (state_q != ST_IDLE);
	assign accept       = item_valid && !item_stall;
	assign slot_free    = !out_valid_q || !result_stall;
	assign result_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.div_sel = mascu_pkg::DIV_SUM;
		case (state_q)
			ST_IDLE: begin
				cmd.load = item_valid;
				if (item_valid && item_last) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.empty) begin
					state_d = ST_DONE;
				end else begin
					cmd.div_start = 1'b1;
					state_d = ST_MEAN;
				end
			end
			ST_MEAN: begin
				if (sts.div_done) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = mascu_pkg::DIV_SQ;
					state_d = ST_MSQ;
				end
			end
			ST_MSQ: begin
				if (sts.div_done) begin
					state_d = ST_VAR;
				end
			end
			ST_VAR: begin
				cmd.sqrt_start = 1'b1;
				state_d = ST_SQRT;
			end
			ST_SQRT: begin
				if (sts.sqrt_done) begin
					state_d = ST_CUT;
				end
			end
			ST_CUT: begin
				cmd.cut_cap = 1'b1;
				state_d = ST_PASS;
			end
			ST_PASS: begin
				// final average runs here too, after the pass
				cmd.pass_en = !res_wait_q;
				cmd.div_sel = mascu_pkg::DIV_ACC;
				if (res_wait_q) begin
					if (sts.div_done) begin
						state_d = ST_DONE;
					end
				end else if (sts.pass_done) begin
					if (sts.qual_zero) begin
						state_d = ST_DONE;
					end else begin
						cmd.div_start = 1'b1;
					end
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					cmd.clear    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			res_wait_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q != ST_PASS) begin
				res_wait_q <= 1'b0;
			end else if (cmd.div_start) begin
				res_wait_q <= 1'b1;
			end
		end
	end

	a_last_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item_last |=> state_q == ST_CHECK)
		else $error("last word did not start the computation");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !result_stall))
		else $error("result word overwritten while stalled");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !sts.div_busy)
		else $error("divider restarted while busy");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !cmd.div_start && !cmd.sqrt_start && !cmd.pass_en)
		else $error("sample loaded during computation");

endmodule

// File: test/mean_above_sigma_cutoff_unit_tb.sv
// testbench for the mean-above-sigma-cutoff unit: directed and random sets checked against a predictor
`timescale 1ns / 100ps

class cutoff_scoreboard;
	localparam int CAPACITY = 1024;

	logic signed [23:0] kept[$];
	logic               dropped;
	logic signed [4:0]  multiplier;
	mascu_pkg::out_t    awaited[$];
	int                 mismatches;

	function new();
		kept.delete();
		dropped = 1'b0;
		multiplier = mascu_pkg::MULT_RESET;
		mismatches = 0;
	endfunction

	function longint floor_quot(longint num, longint den);
		longint q;
		q = num / den;
		if ((num % den != 0) && (num < 0))
			q = q - 1;
		return q;
	endfunction

	function longint int_root(longint v);
		longint lo, hi, mid;
		lo = 0;
		hi = 64'd3037000499;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			if (mid * mid <= v)
				lo = mid;
			else
				hi = mid - 1;
		end
		return lo;
	endfunction

	// note an accepted input word; work out the result when it closes a set
	function void note_word(mascu_pkg::in_t w);
		mascu_pkg::out_t r;
		longint n, sum, sq, mean, msq, var_q, sig, cut, acc, qual;
		if (w.sample_valid) begin
			if (kept.size() < CAPACITY)
				kept.insert(kept.size(), w.sample_value);
			else
				dropped = 1'b1;
		end
		if (!w.last_sample)
			return;
		r = '0;
		r.no_result = 1'b1;
		n = kept.size();
		if (n > 0) begin
			sum = 0;
			sq = 0;
			foreach (kept[i]) begin
				sum += kept[i];
				sq += longint'(kept[i]) * longint'(kept[i]);
			end
			mean = floor_quot(sum, n);
			msq = sq / n;
			var_q = msq - mean * mean;
			if (var_q < 0)
				var_q = 0;
			sig = int_root(var_q);
			cut = mean + longint'(multiplier) * sig;
			acc = 0;
			qual = 0;
			foreach (kept[i])
				if (kept[i] >= cut) begin
					acc += kept[i];
					qual++;
				end
			if (qual > 0) begin
				r.mean_above_cutoff = 24'(floor_quot(acc, qual));
				r.no_result = 1'b0;
				r.qualifying_count = 11'(qual);
			end
		end
		r.overflow_dropped = dropped;
		awaited.insert(awaited.size(), r);
		kept.delete();
		dropped = 1'b0;
	endfunction

	function void check_result(mascu_pkg::out_t got);
		mascu_pkg::out_t exp_r;
		if (awaited.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result word %h", got);
			return;
		end
		exp_r = awaited.pop_front();
		if (got.mean_above_cutoff !== exp_r.mean_above_cutoff ||
				got.no_result !== exp_r.no_result ||
				got.overflow_dropped !== exp_r.overflow_dropped ||
				got.qualifying_count !== exp_r.qualifying_count) begin
			mismatches++;
			if (mismatches <= 10)
				$display({"result mismatch: mean exp %0d got %0d, none exp %b got %b, ",
					"drop exp %b got %b, count exp %0d got %0d"},
					exp_r.mean_above_cutoff, got.mean_above_cutoff,
					exp_r.no_result, got.no_result,
					exp_r.overflow_dropped, got.overflow_dropped,
					exp_r.qualifying_count, got.qualifying_count);
		end
	endfunction
endclass

module mean_above_sigma_cutoff_unit_tb;

	localparam longint CYCLE_LIMIT = 3000000;
	localparam int      SETTLE     = 400;

	logic            clk;
	logic            arst_n;
	logic            item_valid;
	logic            item_stall;
	mascu_pkg::in_t  item;
	logic            result_valid;
	logic            result_stall;
	mascu_pkg::out_t result;
	logic            cfg_write;
	logic [mascu_pkg::MULT_W-1:0] cfg_data;

	cutoff_scoreboard board;
	longint          cycles = 0;
	int              burst_left;
	logic            stall_mode = 1'b0;

	mean_above_sigma_cutoff_unit dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.cfg_write(cfg_write), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
		if (arst_n && result_valid && !result_stall)
			board.check_result(result);
	end

	// receiver stall pattern: quiet stretches and busy stretches
	always @(negedge clk) begin
		if ($urandom_range(0, 99) == 0)
			stall_mode <= ~stall_mode;
		result_stall <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b0;
	end

	// send one word, with a bursty sender; valid drops only for a gap
	task automatic send_word(input logic signed [23:0] v, input logic vld, input logic lst);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		item_valid <= 1'b1;
		item <= '{sample_value: v, sample_valid: vld, last_sample: lst};
		do @(posedge clk); while (item_stall);
		board.note_word(item);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		item_valid <= 1'b0;
		while (board.awaited.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic set_multiplier(input logic signed [4:0] m);
		wait_idle();
		cfg_write <= 1'b1;
		cfg_data <= m;
		@(negedge clk);
		cfg_write <= 1'b0;
		board.multiplier = m;
	endtask

	function automatic logic signed [23:0] pick_sample();
		case ($urandom_range(0, 5))
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			2: return 24'(int'($urandom_range(0, 255)) - 128);
			default: return 24'($urandom);
		endcase
	endfunction

	// one set of n valid samples with some skipped words mixed in
	task automatic send_set(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_word(24'($urandom), 1'b0, 1'b0);
			send_word(pick_sample(), 1'b1, i == n - 1);
		end
		if (n == 0)
			send_word(24'($urandom), 1'b0, 1'b1);
	endtask

	initial begin
		logic signed [4:0] mults[7];
		int sent;
		board = new();
		burst_left = 0;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_write = 1'b0;
		cfg_data = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty set, extremes, all equal, a single sample, a set closed by a skipped word
		send_word(24'sh0, 1'b0, 1'b1);
		send_word(24'sh7FFFFF, 1'b1, 1'b0);
		send_word(24'sh800000, 1'b1, 1'b1);
		send_word(24'sh000100, 1'b1, 1'b0);
		send_word(24'sh000100, 1'b1, 1'b0);
		send_word(24'sh000100, 1'b1, 1'b1);
		send_word(-24'sd5, 1'b1, 1'b1);
		send_word(24'sh800000, 1'b1, 1'b0);
		send_word(24'sh800000, 1'b1, 1'b0);
		send_word(24'sh7FFFFF, 1'b0, 1'b1);
		// large positive multiplier with spread leaves nothing qualifying
		set_multiplier(5'sd15);
		send_word(24'sd0, 1'b1, 1'b0);
		send_word(24'sd1000, 1'b1, 1'b1);
		set_multiplier(-5'sd16);
		send_word(-24'sd300, 1'b1, 1'b0);
		send_word(24'sd7, 1'b1, 1'b0);
		send_word(24'sd300, 1'b1, 1'b1);

		// full store, then dropped words
		set_multiplier(5'sd1);
		for (int i = 0; i < 1030; i++)
			send_word(pick_sample(), 1'b1, i == 1029);

		mults = '{5'sd0, -5'sd8, 5'sd8, 5'sd2, -5'sd1, 5'sd15, -5'sd16};
		sent = 1030;
		foreach (mults[k]) begin
			set_multiplier(mults[k]);
			for (int s = 0; s < 20; s++) begin
				int n;
				n = $urandom_range(0, 3) == 0 ? $urandom_range(0, 2) : $urandom_range(3, 16);
				send_set(n);
				sent += n;
			end
		end
		while (sent < 2000) begin
			int n;
			n = $urandom_range(1, 12);
			send_set(n);
			sent += n;
		end

		wait_idle();
		if (board.mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
